>>> rtl/rc5_pkg.sv
// Shared types, constants and rotate helpers for the RC5 CBC block cipher.
package rc5_pkg;

  localparam logic [31:0] MAGIC_P = 32'hB7E15163;
  localparam logic [31:0] MAGIC_Q = 32'h9E3779B9;

  // key word store depth and index width
  localparam int KEY_WORD_MAX = 4;
  localparam int KW_W         = 2;

  // widest table index / bank address over the legal ROUNDS range
  localparam int IDX_MAX_W  = 9;
  localparam int ADDR_MAX_W = 8;

  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_LOW        = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_HIGH       = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_INITIAL_VECTOR = 2'd2;

  typedef struct packed {
    logic        operation;
    logic        first_block;
    logic [31:0] data_lo;
    logic [31:0] data_hi;
  } in_t;

  typedef struct packed {
    logic [31:0] result_lo;
    logic [31:0] result_hi;
  } out_t;

  typedef struct packed {
    logic                 we;
    logic [CFG_IDX_W-1:0] idx;
    logic [63:0]          data;
  } cfg_wr_t;

  typedef struct packed {
    logic                  capture;
    logic                  key_load;
    logic                  kx_step;
    logic                  kx_fresh;
    logic [IDX_MAX_W-1:0]  kx_idx;
    logic [KW_W-1:0]       kx_word;
    logic [ADDR_MAX_W-1:0] rd_addr;
    logic                  ci_load;
    logic                  ci_step;
    logic                  decrypt;
    logic                  whiten;
    logic                  out_load;
  } cmd_t;

  typedef struct packed {
    logic out_free;
  } sts_t;

  function automatic logic [31:0] rotl(input logic [31:0] v, input logic [4:0] s);
    logic [63:0] t;
    t = {v, v} << s;
    return t[63:32];
  endfunction

  function automatic logic [31:0] rotr(input logic [31:0] v, input logic [4:0] s);
    logic [63:0] t;
    t = {v, v} >> s;
    return t[31:0];
  endfunction

endpackage

>>> rtl/rc5_ctrl.sv
// Sequencer for key expansion, cipher rounds and result hand-off.
module rc5_ctrl #(
  parameter int ROUNDS    = 12,
  parameter int KEY_BYTES = 16
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  input  rc5_pkg::in_t  in_req_i,
  output logic          in_ready_o,
  input  rc5_pkg::sts_t sts_i,
  output rc5_pkg::cmd_t cmd_o
);

  localparam int TABLE_WORDS = 2 * (ROUNDS + 1);
  localparam int IDX_W       = $clog2(TABLE_WORDS);
  localparam int BA_W        = IDX_W - 1;
  localparam int NWORDS      = (KEY_BYTES + 3) / 4;

  localparam logic [IDX_W-1:0]         IDX_LAST  = IDX_W'(TABLE_WORDS - 1);
  localparam logic [BA_W-1:0]          RND_LAST  = BA_W'(ROUNDS);
  localparam logic [rc5_pkg::KW_W-1:0] WORD_LAST = rc5_pkg::KW_W'(NWORDS - 1);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_KLOAD = 3'd1;
  localparam logic [2:0] ST_KEXP = 3'd2;
  localparam logic [2:0] ST_PREF = 3'd3;
  localparam logic [2:0] ST_RUN = 3'd4;
  localparam logic [2:0] ST_FIN = 3'd5;

  logic [2:0]               state_q, state_d;
  logic [IDX_W-1:0]         idx_q, idx_d;
  logic [1:0]               pass_q, pass_d;
  logic [rc5_pkg::KW_W-1:0] word_q, word_d;
  logic [BA_W-1:0]          ci_q, ci_d;
  logic                     op_q, op_d;

  logic             in_acc;
  logic [IDX_W-1:0] idx_next;
  logic [BA_W-1:0]  ci_next;
  logic [BA_W-1:0]  ci_first;
  logic             ci_last;

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;

  assign idx_next = (idx_q == IDX_LAST) ? '0 : idx_q + 1'b1;
  assign ci_next  = op_q ? ci_q - 1'b1 : ci_q + 1'b1;
  assign ci_first = op_q ? RND_LAST : '0;
  assign ci_last  = op_q ? (ci_q == '0) : (ci_q == RND_LAST);

  always_comb begin
    state_d = state_q;
    idx_d   = idx_q;
    pass_d  = pass_q;
    word_d  = word_q;
    ci_d    = ci_q;
    op_d    = op_q;
    cmd_o   = '0;
    cmd_o.decrypt = op_q;
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          cmd_o.capture = 1'b1;
          op_d    = in_req_i.operation;
          state_d = in_req_i.first_block ? ST_KLOAD : ST_PREF;
        end
      end
      ST_KLOAD: begin
        cmd_o.key_load = 1'b1;
        idx_d   = '0;
        pass_d  = '0;
        word_d  = '0;
        state_d = ST_KEXP;
      end
      ST_KEXP: begin
        cmd_o.kx_step  = 1'b1;
        cmd_o.kx_fresh = (pass_q == 2'd0);
        cmd_o.kx_idx   = rc5_pkg::IDX_MAX_W'(idx_q);
        cmd_o.kx_word  = word_q;
        // prefetch the entry used by the next step
        cmd_o.rd_addr  = rc5_pkg::ADDR_MAX_W'(idx_next[IDX_W-1:1]);
        idx_d  = idx_next;
        word_d = (word_q == WORD_LAST) ? '0 : word_q + 1'b1;
        if (idx_q == IDX_LAST) begin
          pass_d = pass_q + 1'b1;
          if (pass_q == 2'd2) begin
            state_d = ST_PREF;
          end
        end
      end
      ST_PREF: begin
        cmd_o.ci_load = 1'b1;
        cmd_o.rd_addr = rc5_pkg::ADDR_MAX_W'(ci_first);
        ci_d    = ci_first;
        state_d = ST_RUN;
      end
      ST_RUN: begin
        cmd_o.ci_step = 1'b1;
        cmd_o.whiten  = (ci_q == '0);
        cmd_o.rd_addr = rc5_pkg::ADDR_MAX_W'(ci_last ? ci_q : ci_next);
        if (ci_last) begin
          state_d = ST_FIN;
        end else begin
          ci_d = ci_next;
        end
      end
      ST_FIN: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      idx_q   <= '0;
      pass_q  <= '0;
      word_q  <= '0;
      ci_q    <= '0;
      op_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      pass_q  <= pass_d;
      word_q  <= word_d;
      ci_q    <= ci_d;
      op_q    <= op_d;
    end
  end

  a_out_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |-> sts_i.out_free)
    else $error("result loaded while output register still held");

  a_first_expands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && in_req_i.first_block) |=> (state_q == ST_KLOAD))
    else $error("first block did not start key expansion");

  a_exp_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_KEXP && pass_q == 2'd2 && idx_q == IDX_LAST) |=> (state_q == ST_PREF))
    else $error("key expansion did not end after three passes");

  a_round_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RUN) |-> (ci_q <= RND_LAST))
    else $error("round index out of range");

endmodule

>>> rtl/rc5_dp.sv
// Datapath: config registers, subkey banks, key expansion step, round unit, chain.
module rc5_dp #(
  parameter int ROUNDS    = 12,
  parameter int KEY_BYTES = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  rc5_pkg::cfg_wr_t cfg_i,
  input  rc5_pkg::in_t     in_req_i,
  input  rc5_pkg::cmd_t    cmd_i,
  output rc5_pkg::sts_t    sts_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output rc5_pkg::out_t    out_data_o
);

  localparam int BANK_DEPTH = ROUNDS + 1;
  localparam int IDX_W      = $clog2(2 * BANK_DEPTH);
  localparam int BA_W       = IDX_W - 1;

  logic [63:0] key_low_q, key_high_q, iv_q;
  logic [63:0] chain_q;
  logic [63:0] blk_q;

  // subkeys split by index parity so one round reads both halves at once
  logic [31:0] even_mem [BANK_DEPTH];
  logic [31:0] odd_mem  [BANK_DEPTH];
  logic [31:0] even_rd_q, odd_rd_q;

  logic [31:0] kw_q [rc5_pkg::KEY_WORD_MAX];
  logic [31:0] magic_q;
  logic [31:0] kx_a_q, kx_b_q;
  logic [31:0] ci_a_q, ci_a_d, ci_b_q, ci_b_d;

  rc5_pkg::out_t out_q;
  logic          out_valid_q;

  logic [127:0]     key_bytes;
  logic [IDX_W-1:0] wr_idx;
  logic [BA_W-1:0]  rd_addr;
  logic [31:0]      s_src, s_new, ab, l_new;
  logic [63:0]      cipher_blk, res;

  assign wr_idx  = cmd_i.kx_idx[IDX_W-1:0];
  assign rd_addr = cmd_i.rd_addr[BA_W-1:0];

  // bytes past the key length read as zero
  always_comb begin
    key_bytes = {key_high_q, key_low_q};
    for (int n = 0; n < 16; n++) begin
      if (n >= KEY_BYTES) begin
        key_bytes[8*n +: 8] = 8'h00;
      end
    end
  end

  assign s_src = cmd_i.kx_fresh ? magic_q : (wr_idx[0] ? odd_rd_q : even_rd_q);
  assign s_new = rc5_pkg::rotl(s_src + kx_a_q + kx_b_q, 5'd3);
  assign ab    = s_new + kx_b_q;
  assign l_new = rc5_pkg::rotl(kw_q[cmd_i.kx_word] + ab, ab[4:0]);

  always_comb begin
    logic [31:0] a_t, b_t;
    a_t    = '0;
    b_t    = '0;
    ci_a_d = ci_a_q;
    ci_b_d = ci_b_q;
    if (cmd_i.ci_load) begin
      ci_a_d = blk_q[31:0]  ^ (cmd_i.decrypt ? 32'h0 : chain_q[31:0]);
      ci_b_d = blk_q[63:32] ^ (cmd_i.decrypt ? 32'h0 : chain_q[63:32]);
    end else if (cmd_i.ci_step) begin
      if (!cmd_i.decrypt) begin
        if (cmd_i.whiten) begin
          ci_a_d = ci_a_q + even_rd_q;
          ci_b_d = ci_b_q + odd_rd_q;
        end else begin
          a_t    = rc5_pkg::rotl(ci_a_q ^ ci_b_q, ci_b_q[4:0]) + even_rd_q;
          ci_a_d = a_t;
          ci_b_d = rc5_pkg::rotl(ci_b_q ^ a_t, a_t[4:0]) + odd_rd_q;
        end
      end else begin
        if (cmd_i.whiten) begin
          ci_a_d = ci_a_q - even_rd_q;
          ci_b_d = ci_b_q - odd_rd_q;
        end else begin
          b_t    = rc5_pkg::rotr(ci_b_q - odd_rd_q, ci_a_q[4:0]) ^ ci_a_q;
          ci_b_d = b_t;
          ci_a_d = rc5_pkg::rotr(ci_a_q - even_rd_q, b_t[4:0]) ^ b_t;
        end
      end
    end
  end

  assign cipher_blk = {ci_b_q, ci_a_q};
  assign res        = cipher_blk ^ (cmd_i.decrypt ? chain_q : 64'h0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_low_q  <= '0;
      key_high_q <= '0;
      iv_q       <= '0;
    end else if (cfg_i.we) begin
      case (cfg_i.idx)
        rc5_pkg::CFG_KEY_LOW:        key_low_q  <= cfg_i.data;
        rc5_pkg::CFG_KEY_HIGH:       key_high_q <= cfg_i.data;
        rc5_pkg::CFG_INITIAL_VECTOR: iv_q       <= cfg_i.data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chain_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.capture && in_req_i.first_block) begin
        chain_q <= iv_q;
      end else if (cmd_i.out_load) begin
        chain_q <= cmd_i.decrypt ? blk_q : cipher_blk;
      end
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      blk_q <= {in_req_i.data_hi, in_req_i.data_lo};
    end
    if (cmd_i.key_load) begin
      magic_q <= rc5_pkg::MAGIC_P;
      kx_a_q  <= '0;
      kx_b_q  <= '0;
      for (int w = 0; w < rc5_pkg::KEY_WORD_MAX; w++) begin
        kw_q[w] <= key_bytes[32*w +: 32];
      end
    end else if (cmd_i.kx_step) begin
      magic_q <= magic_q + rc5_pkg::MAGIC_Q;
      kx_a_q  <= s_new;
      kx_b_q  <= l_new;
      kw_q[cmd_i.kx_word] <= l_new;
    end
    ci_a_q <= ci_a_d;
    ci_b_q <= ci_b_d;
    if (cmd_i.out_load) begin
      out_q.result_lo <= res[31:0];
      out_q.result_hi <= res[63:32];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.kx_step) begin
      if (wr_idx[0]) begin
        odd_mem[wr_idx[IDX_W-1:1]] <= s_new;
      end else begin
        even_mem[wr_idx[IDX_W-1:1]] <= s_new;
      end
    end
    even_rd_q <= even_mem[rd_addr];
    odd_rd_q  <= odd_mem[rd_addr];
  end

  assign sts_o.out_free = !out_valid_q || out_ready_i;
  assign out_valid_o    = out_valid_q;
  assign out_data_o     = out_q;

endmodule

>>> rtl/rc5_cbc_block_cipher.sv
// RC5-32 CBC block cipher top level: one block per request, encrypt or decrypt.
// Per block: accept, subkey prefetch, whitening and rounds, then a wait for the output
// register to be free; a first block adds a key load and three passes of key expansion.
// A new block is accepted only once the last result is loaded; the single round unit
// does one round per cycle over two registered subkey bank reads.
// Reset: async active low; clears config registers, chain value and control state.
module rc5_cbc_block_cipher #(
  parameter int ROUNDS    = 12,
  parameter int KEY_BYTES = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [rc5_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [63:0]                   cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  rc5_pkg::in_t                  in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output rc5_pkg::out_t                 out_data_o
);

  rc5_pkg::cfg_wr_t cfg;
  rc5_pkg::cmd_t    cmd;
  rc5_pkg::sts_t    sts;

  assign cfg.we   = cfg_we_i;
  assign cfg.idx  = cfg_idx_i;
  assign cfg.data = cfg_data_i;

  rc5_ctrl #(
    .ROUNDS    (ROUNDS),
    .KEY_BYTES (KEY_BYTES)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_req_i   (in_data_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  rc5_dp #(
    .ROUNDS    (ROUNDS),
    .KEY_BYTES (KEY_BYTES)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .in_req_i    (in_data_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule
